// File: design/pcx_rle_image_decoder_assert.svh
// ----------------------------------------------------------------------------
// PCX RLE decoder assertion macros
// Concurrent checks clocked on clk and held off while rst is high.
// ----------------------------------------------------------------------------
`ifndef PCX_RLE_IMAGE_DECODER_ASSERT_SVH
`define PCX_RLE_IMAGE_DECODER_ASSERT_SVH

// Check a property on every rising edge outside reset.
`define PCX_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition on a valid result holds at the same edge.
`define PCX_ASSERT_ON_VALID(lbl, cond, msg) \
  `PCX_ASSERT_CLK(lbl, m_axis_tvalid |-> (cond), msg)

`endif

// File: design/pcxrle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCX RLE decoder package
// Shared constants and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package pcxrle_pkg;

  localparam int HDR_BYTES   = 128;
  localparam int HDR_CNT_W   = $clog2(HDR_BYTES);
  localparam logic [HDR_CNT_W-1:0] HDR_LAST    = HDR_CNT_W'(HDR_BYTES - 1);
  localparam logic [HDR_CNT_W-1:0] BOUND_FIRST = HDR_CNT_W'(4);
  localparam logic [HDR_CNT_W-1:0] BOUND_LAST  = HDR_CNT_W'(11);

  localparam logic [7:0] RUN_MASK   = 8'hC0;
  localparam logic [7:0] COUNT_MASK = 8'h3F;
  localparam logic [7:0] PAL_MARKER = 8'd12;

  localparam int PAL_SIZE  = 256;
  localparam int PAL_IDX_W = (PAL_SIZE > 1) ? $clog2(PAL_SIZE) : 1;

  localparam int COORD_W = 16;
  localparam int RUN_W   = 6;
  localparam int COMP_W  = 6;
  localparam int TDATA_W = 64;

  // Result kinds carried on the output tuser
  localparam logic KIND_PIXEL   = 1'b0;
  localparam logic KIND_PALETTE = 1'b1;

  // Palette byte positions within one entry
  localparam logic [1:0] POS_RED   = 2'd0;
  localparam logic [1:0] POS_GREEN = 2'd1;
  localparam logic [1:0] POS_BLUE  = 2'd2;

  typedef struct packed {
    logic restart;      // file_start seen on the accepted byte
    logic hdr_byte;     // accepted byte is a header byte
    logic img_byte;     // accepted byte is an image byte
    logic expand_step;  // emit the next pixel of a held run
    logic pal_start;    // marker accepted, open the palette
    logic pal_byte;     // accepted byte is a palette byte
  } pcx_cmd_t;

  typedef struct packed {
    logic hdr_last;     // current header byte is the final one
    logic empty;        // image bounds give no pixels
    logic img_pixel;    // current byte emits a first pixel
    logic img_more;     // ... and leaves pixels for expansion
    logic exp_done;     // held run emits its final pixel
    logic frame_end;    // pixel at the current position closes the image
    logic marker_ok;    // current byte is the palette marker
    logic pal_end;      // current byte completes the last palette entry
    logic out_free;     // output register can take a result
  } pcx_stat_t;

endpackage

// File: design/pcxrle_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCX RLE decoder datapath
// Header capture, run and position counters, palette assembly, result register.
// ----------------------------------------------------------------------------
module pcxrle_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [7:0]                   data_byte,
  input  pcxrle_pkg::pcx_cmd_t         cmd,
  output pcxrle_pkg::pcx_stat_t        stat,
  input  logic                         m_tready,
  output logic                         m_tvalid,
  output logic [pcxrle_pkg::TDATA_W-1:0] m_tdata,
  output logic                         m_tuser,
  output logic                         m_tlast
);

  logic [pcxrle_pkg::HDR_CNT_W-1:0] header_count;
  logic [pcxrle_pkg::COORD_W-1:0]   bounds [4];
  logic [pcxrle_pkg::COORD_W-1:0]   column;
  logic [pcxrle_pkg::COORD_W-1:0]   line;
  logic [pcxrle_pkg::RUN_W-1:0]     run_length;
  logic                             run_pending;
  logic [pcxrle_pkg::RUN_W-1:0]     remaining;
  logic [7:0]                       pix_value;
  logic [1:0]                       pal_pos;
  logic [pcxrle_pkg::PAL_IDX_W-1:0] pal_entry;
  logic [7:0]                       colour_hold [2];

  logic                             out_valid;
  logic                             out_kind;
  logic                             out_last;
  logic [pcxrle_pkg::COORD_W-1:0]   out_x;
  logic [pcxrle_pkg::COORD_W-1:0]   out_y;
  logic [7:0]                       out_value;
  logic [pcxrle_pkg::COMP_W-1:0]    out_red;
  logic [pcxrle_pkg::COMP_W-1:0]    out_green;
  logic [pcxrle_pkg::COMP_W-1:0]    out_blue;

  logic [pcxrle_pkg::HDR_CNT_W-1:0] hdr_idx;
  logic [pcxrle_pkg::HDR_CNT_W-1:0] hdr_off;
  logic                             hdr_in_bounds;
  logic [pcxrle_pkg::COORD_W-1:0]   last_col;
  logic [pcxrle_pkg::COORD_W-1:0]   last_line;
  logic                             at_end_col;
  logic                             at_end_line;
  logic                             run_code;
  logic [pcxrle_pkg::RUN_W-1:0]     img_count;
  logic                             img_emit;
  logic                             pix_emit;
  logic [pcxrle_pkg::RUN_W-1:0]     emit_count;
  logic                             pix_last;
  logic                             pal_emit;

  assign hdr_idx       = cmd.restart ? '0 : header_count;
  assign hdr_off       = hdr_idx - pcxrle_pkg::BOUND_FIRST;
  assign hdr_in_bounds = (hdr_idx >= pcxrle_pkg::BOUND_FIRST) &&
                         (hdr_idx <= pcxrle_pkg::BOUND_LAST);

  // Bounds order: xmin, ymin, xmax, ymax
  assign last_col    = bounds[2] - bounds[0];
  assign last_line   = bounds[3] - bounds[1];
  assign at_end_col  = (column == last_col);
  assign at_end_line = (line == last_line);

  assign run_code  = !run_pending &&
                     ((data_byte & pcxrle_pkg::RUN_MASK) == pcxrle_pkg::RUN_MASK);
  assign img_count = run_pending ? run_length : pcxrle_pkg::RUN_W'(1);

  assign img_emit   = cmd.img_byte && !run_code && (img_count != '0);
  assign pix_emit   = img_emit || cmd.expand_step;
  assign emit_count = cmd.expand_step ? remaining : img_count;
  assign pix_last   = (emit_count == pcxrle_pkg::RUN_W'(1)) || at_end_col;
  assign pal_emit   = cmd.pal_byte && (pal_pos == pcxrle_pkg::POS_BLUE);

  always_comb begin
    stat.hdr_last  = (header_count == pcxrle_pkg::HDR_LAST);
    stat.empty     = (bounds[2] < bounds[0]) || (bounds[3] < bounds[1]);
    stat.img_pixel = !run_code && (img_count != '0);
    stat.img_more  = !((img_count == pcxrle_pkg::RUN_W'(1)) || at_end_col);
    stat.exp_done  = (remaining == pcxrle_pkg::RUN_W'(1)) || at_end_col;
    stat.frame_end = at_end_col && at_end_line;
    stat.marker_ok = (data_byte == pcxrle_pkg::PAL_MARKER);
    stat.pal_end   = (pal_pos == pcxrle_pkg::POS_BLUE) &&
                     (pal_entry == pcxrle_pkg::PAL_IDX_W'(pcxrle_pkg::PAL_SIZE - 1));
    stat.out_free  = !out_valid || m_tready;
  end

  // Control and counter state
  always_ff @(posedge clk) begin
    if (rst) begin
      header_count <= '0;
      bounds[0]    <= '0;
      bounds[1]    <= '0;
      bounds[2]    <= '0;
      bounds[3]    <= '0;
      column       <= '0;
      line         <= '0;
      run_length   <= '0;
      run_pending  <= 1'b0;
      remaining    <= '0;
      pal_pos      <= pcxrle_pkg::POS_RED;
      pal_entry    <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.hdr_byte) begin
        if (hdr_in_bounds) begin
          if (hdr_idx[0]) begin
            bounds[hdr_off[2:1]][15:8] <= data_byte;
          end else begin
            bounds[hdr_off[2:1]][7:0] <= data_byte;
          end
        end
        if (hdr_idx == pcxrle_pkg::HDR_LAST) begin
          header_count <= '0;
          column       <= '0;
          line         <= '0;
          run_length   <= '0;
          run_pending  <= 1'b0;
        end else begin
          header_count <= hdr_idx + pcxrle_pkg::HDR_CNT_W'(1);
        end
      end

      if (cmd.img_byte) begin
        if (run_code) begin
          run_length  <= pcxrle_pkg::RUN_W'(data_byte & pcxrle_pkg::COUNT_MASK);
          run_pending <= 1'b1;
        end else begin
          run_length  <= '0;
          run_pending <= 1'b0;
        end
      end

      // Advance position by one pixel; wrap at line end, clip the run there
      if (pix_emit) begin
        remaining <= emit_count - pcxrle_pkg::RUN_W'(1);
        if (at_end_col) begin
          column <= '0;
          line   <= at_end_line ? '0 : line + pcxrle_pkg::COORD_W'(1);
        end else begin
          column <= column + pcxrle_pkg::COORD_W'(1);
        end
      end

      if (cmd.pal_start) begin
        pal_pos   <= pcxrle_pkg::POS_RED;
        pal_entry <= '0;
      end else if (cmd.pal_byte) begin
        if (pal_emit) begin
          pal_pos   <= pcxrle_pkg::POS_RED;
          pal_entry <= pal_entry + pcxrle_pkg::PAL_IDX_W'(1);
        end else begin
          pal_pos <= pal_pos + 2'd1;
        end
      end

      if (pix_emit || pal_emit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (img_emit) begin
      pix_value <= data_byte;
    end
    if (cmd.pal_byte && (pal_pos == pcxrle_pkg::POS_RED)) begin
      colour_hold[0] <= data_byte;
    end
    if (cmd.pal_byte && (pal_pos == pcxrle_pkg::POS_GREEN)) begin
      colour_hold[1] <= data_byte;
    end
    if (pix_emit) begin
      out_kind  <= pcxrle_pkg::KIND_PIXEL;
      out_x     <= column;
      out_y     <= line;
      out_value <= cmd.expand_step ? pix_value : data_byte;
      out_red   <= '0;
      out_green <= '0;
      out_blue  <= '0;
      out_last  <= pix_last;
    end else if (pal_emit) begin
      out_kind  <= pcxrle_pkg::KIND_PALETTE;
      out_x     <= '0;
      out_y     <= '0;
      out_value <= 8'(pal_entry);
      out_red   <= colour_hold[0][7:2];
      out_green <= colour_hold[1][7:2];
      out_blue  <= data_byte[7:2];
      out_last  <= 1'b1;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;
  assign m_tdata  = {6'b0, out_blue, out_green, out_red, out_value, out_y, out_x};

endmodule

// File: design/pcxrle_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCX RLE decoder controller
// Stream phase sequencing and input handshake.
// ----------------------------------------------------------------------------
module pcxrle_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  file_start,
  output logic                  s_tready,
  input  pcxrle_pkg::pcx_stat_t stat,
  output pcxrle_pkg::pcx_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_HEADER,
    S_IMAGE,
    S_EXPAND,
    S_MARKER,
    S_PALETTE,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign s_tready = (state != S_EXPAND) && stat.out_free;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    if (accept && file_start) begin
      // restart: this byte is header byte zero
      cmd.restart  = 1'b1;
      cmd.hdr_byte = 1'b1;
      state_next   = S_HEADER;
    end else begin
      case (state)
        S_HEADER: begin
          if (accept) begin
            cmd.hdr_byte = 1'b1;
            if (stat.hdr_last) begin
              state_next = stat.empty ? S_MARKER : S_IMAGE;
            end
          end
        end
        S_IMAGE: begin
          if (accept) begin
            cmd.img_byte = 1'b1;
            if (stat.img_pixel && stat.frame_end) begin
              state_next = S_MARKER;
            end else if (stat.img_pixel && stat.img_more) begin
              state_next = S_EXPAND;
            end
          end
        end
        S_EXPAND: begin
          if (stat.out_free) begin
            cmd.expand_step = 1'b1;
            if (stat.frame_end) begin
              state_next = S_MARKER;
            end else if (stat.exp_done) begin
              state_next = S_IMAGE;
            end
          end
        end
        S_MARKER: begin
          if (accept) begin
            if (stat.marker_ok) begin
              cmd.pal_start = 1'b1;
              state_next    = S_PALETTE;
            end else begin
              state_next = S_DONE;
            end
          end
        end
        S_PALETTE: begin
          if (accept) begin
            cmd.pal_byte = 1'b1;
            if (stat.pal_end) begin
              state_next = S_DONE;
            end
          end
        end
        S_DONE: begin
          // drop bytes until the next file start
        end
        default: begin
          state_next = S_HEADER;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_HEADER;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: design/pcx_rle_image_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCX RLE image decoder
// Decodes an 8-bit PCX byte stream into positioned pixels and palette entries.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_axis: one file byte per transaction, tuser flags the
//   first header byte of a file and restarts the decoder on it.
//   Output channel m_axis: one pixel or palette entry per transaction;
//   tuser gives the kind (pixel or palette), tlast marks the final result
//   caused by one input byte.
//   Output register: a result appears on m_axis in the cycle after the byte
//   that causes it is accepted.
//   Throughput: header, literal, marker and palette bytes are accepted one
//   per cycle while the output is free. For the value byte of a run byte pair,
//   the controller holds the input while the single result register issues
//   one pixel per cycle whenever m_axis is ready. Runs are clipped at the line end.
//   Reset: the decoder waits for header bytes with all counters cleared;
//   the output channel is empty.
//   Stall: while m_axis is not ready and holds a result, s_axis is not
//   ready either; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module pcx_rle_image_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] file_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [15:0] pos_x, [31:16] pos_y, [39:32] value,
                                      // [45:40] red, [51:46] green, [57:52] blue, zero pad
  output logic        m_axis_tuser,   // [0] kind
  output logic        m_axis_tlast    // last_of_run
);

  pcxrle_pkg::pcx_cmd_t  cmd;
  pcxrle_pkg::pcx_stat_t stat;

  // Phase sequencing and input handshake
  pcxrle_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_axis_tvalid),
    .file_start (s_axis_tuser),
    .s_tready   (s_axis_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Header capture, counters, palette assembly and result register
  pcxrle_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .data_byte (s_axis_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .m_tready  (m_axis_tready),
    .m_tvalid  (m_axis_tvalid),
    .m_tdata   (m_axis_tdata),
    .m_tuser   (m_axis_tuser),
    .m_tlast   (m_axis_tlast)
  );

endmodule

// File: design/pcxrle_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCX RLE decoder port checker
// Checks result channel behaviour seen on the top-level ports.
// ----------------------------------------------------------------------------
`include "pcx_rle_image_decoder_assert.svh"

module pcxrle_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  logic in_seen;

  // Input bytes are only observed here; keep them visible to the checker
  assign in_seen = s_axis_tvalid && s_axis_tready && (s_axis_tuser || (s_axis_tdata != 8'd0));

  // A stalled transaction holds its result
  `PCX_ASSERT_CLK(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // Palette entries carry no position
  `PCX_ASSERT_ON_VALID(a_pal_no_pos, !m_axis_tuser || (m_axis_tdata[31:0] == 32'd0), "palette entry with position")

  // Pixels carry no colour components
  `PCX_ASSERT_ON_VALID(a_pix_no_rgb, m_axis_tuser || (m_axis_tdata[57:40] == 18'd0), "pixel with colour")

  // Each palette entry is the only result of its byte
  `PCX_ASSERT_ON_VALID(a_pal_last, !m_axis_tuser || m_axis_tlast, "palette entry without tlast")

  // Padding bits stay clear; an accepted input never coincides with a malformed result
  `PCX_ASSERT_CLK(a_pad_zero, (m_axis_tvalid || in_seen) |-> (!m_axis_tvalid || (m_axis_tdata[63:58] == 6'd0)), "padding bits set")

endmodule

bind pcx_rle_image_decoder pcxrle_checker u_checker (.*);
